/* hdl/can_tx_queue_with_id_packing_core_assert.svh */
// Assertion macros shared by the checker of the CAN transmit queue.
`ifndef CAN_TX_QUEUE_WITH_ID_PACKING_CORE_ASSERT_SVH
`define CAN_TX_QUEUE_WITH_ID_PACKING_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTXQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTXQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ctxq_pkg.sv */
// Types, codes and constants shared by the CAN transmit queue modules.
package ctxq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] ACT_PROTO = 2'd0;
  localparam logic [1:0] ACT_STD   = 2'd1;
  localparam logic [1:0] ACT_EXT   = 2'd2;
  localparam logic [1:0] ACT_DEQ   = 2'd3;

  localparam logic [1:0] ST_ENQ   = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_DEQ   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [31:0] SRR_IDE_BITS   = 32'h0018_0000;
  localparam logic [31:0] LOW_PART_MASK  = 32'h0007_ffff;
  localparam logic [31:0] HIGH_PART_MASK = 32'hffe0_0000;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  msg_type;
    logic [3:0]  dest_node;
    logic [4:0]  table_number;
    logic [10:0] var_offset;
    logic [28:0] raw_ident;
    logic [3:0]  byte_count;
    logic [63:0] payload;
    logic        passthrough;
  } item_t;

  typedef struct packed {
    logic [31:0] ident;
    logic [3:0]  length;
    logic [63:0] payload;
    logic        mark;
  } entry_t;

endpackage

/* hdl/ctxq_id_pack.sv */
// Builds the queue entry, including the packed identifier word, for one word.
module ctxq_id_pack
  import ctxq_pkg::*;
(
  input  item_t      item,
  input  logic [3:0] own_node_id,
  output entry_t     entry
);

  logic [31:0] proto_word;
  logic [31:0] std_word;
  logic [31:0] ext_word;

  assign proto_word = {item.var_offset, 2'b00, item.msg_type, own_node_id,
                       item.dest_node, item.table_number[3:0],
                       item.table_number[4], 3'b000} | SRR_IDE_BITS;

  assign std_word = {item.raw_ident[10:0], 21'd0};

  // The extended form splits the 29 bits around the SRR and IDE flags.
  assign ext_word = ({2'b00, item.raw_ident, 1'b0} & LOW_PART_MASK)
                  | ({item.raw_ident, 3'b000} & HIGH_PART_MASK)
                  | SRR_IDE_BITS;

  always_comb begin
    entry.length  = item.byte_count;
    entry.payload = item.payload;
    unique case (item.action)
      ACT_PROTO: begin
        entry.ident = proto_word;
        entry.mark  = item.passthrough;
      end
      ACT_STD: begin
        entry.ident = std_word;
        entry.mark  = 1'b0;
      end
      ACT_EXT: begin
        entry.ident = ext_word;
        entry.mark  = 1'b0;
      end
      ACT_DEQ: begin
        entry.ident = '0;
        entry.mark  = 1'b0;
      end
    endcase
  end

endmodule

/* hdl/can_tx_queue_with_id_packing_core.sv */
// Top level of the CAN transmit queue with identifier packing.
//
// Usage: a word is accepted at a rising edge where start is high and busy is
// low. Its action either enqueues a message (protocol, raw 11-bit or raw
// 29-bit identifier) or dequeues the oldest stored message.
// Every accepted word gives exactly one result, shown for one cycle with
// done high. The receiver cannot stall, so results are never held back.
// From acceptance to done, a word passes the input register, then the ring
// access and the result register. A new word may be accepted in every cycle
// while busy is low, so throughput is one word per cycle; the ring memory has
// one write and one read port, which each word uses at most once.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the own
// node id that is placed in protocol identifiers; write it only while idle.
// Reset (rst, synchronous) empties the ring, clears the node id and holds
// busy high for the cycle after reset; the ring contents are not cleared, as
// the entry count guards every read.
module can_tx_queue_with_id_packing_core
  import ctxq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [2:0]  msg_type,
  input  logic [3:0]  dest_node,
  input  logic [4:0]  table_number,
  input  logic [10:0] var_offset,
  input  logic [28:0] raw_ident,
  input  logic [3:0]  byte_count,
  input  logic [63:0] payload,
  input  logic        passthrough,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] tx_ident_word,
  output logic [3:0]  tx_byte_count,
  output logic [63:0] tx_payload,
  output logic        tx_passthrough
);

  // Input register stage.
  logic        in_valid;
  item_t       in_item;

  // Configuration and ring control state.
  logic [3:0]  own_node_id;
  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] read_index;
  logic [CNT_W-1:0] entry_count;
  logic [IDX_W-1:0] write_index_next;
  logic [IDX_W-1:0] read_index_next;
  logic [CNT_W-1:0] entry_count_next;

  // Ring storage and its registered read port.
  entry_t      ring [DEPTH];
  entry_t      rd_entry;
  entry_t      new_entry;

  // Result register stage.
  logic        deq_hit;
  logic [1:0]  status_next;

  logic        is_deq;
  logic        ring_full;
  logic        ring_empty;
  logic        wr_en;
  logic        rd_en;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b1;
      own_node_id <= '0;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        own_node_id <= cfg_data;
      end
    end
  end

  // Capture the accepted word; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_item <= '{action: action, msg_type: msg_type, dest_node: dest_node,
                   table_number: table_number, var_offset: var_offset,
                   raw_ident: raw_ident, byte_count: byte_count,
                   payload: payload, passthrough: passthrough};
    end
  end

  ctxq_id_pack u_id_pack (
    .item        (in_item),
    .own_node_id (own_node_id),
    .entry       (new_entry)
  );

  // Full and empty follow the entry count; a full ring drops enqueues and an
  // empty ring leaves both indices alone on a dequeue.
  assign is_deq     = (in_item.action == ACT_DEQ);
  assign ring_full  = (entry_count == CNT_W'(DEPTH));
  assign ring_empty = (entry_count == '0);
  assign wr_en      = in_valid && !is_deq && !ring_full;
  assign rd_en      = in_valid && is_deq && !ring_empty;

  always_comb begin
    write_index_next = write_index;
    read_index_next  = read_index;
    entry_count_next = entry_count;
    if (wr_en) begin
      write_index_next = (write_index == IDX_W'(DEPTH - 1)) ? '0
                                                             : write_index + 1'b1;
      entry_count_next = entry_count + 1'b1;
    end else if (rd_en) begin
      read_index_next  = (read_index == IDX_W'(DEPTH - 1)) ? '0
                                                            : read_index + 1'b1;
      entry_count_next = entry_count - 1'b1;
    end
  end

  always_comb begin
    if (is_deq) begin
      status_next = ring_empty ? ST_EMPTY : ST_DEQ;
    end else begin
      status_next = ring_full ? ST_FULL : ST_ENQ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      entry_count <= '0;
      done        <= 1'b0;
      deq_hit     <= 1'b0;
      status      <= ST_ENQ;
    end else begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      entry_count <= entry_count_next;
      done        <= in_valid;
      deq_hit     <= rd_en;
      status      <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[write_index] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= ring[read_index];
    end
  end

  // Only a successful dequeue shows the entry; every other result reads zero.
  assign tx_ident_word  = deq_hit ? rd_entry.ident   : '0;
  assign tx_byte_count  = deq_hit ? rd_entry.length  : '0;
  assign tx_payload     = deq_hit ? rd_entry.payload : '0;
  assign tx_passthrough = deq_hit ? rd_entry.mark    : 1'b0;

endmodule

/* hdl/ctxq_checker.sv */
// Port-level checker for the CAN transmit queue, bound to the top level.
`include "can_tx_queue_with_id_packing_core_assert.svh"

module ctxq_checker
  import ctxq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  action,
  input logic        done,
  input logic [1:0]  status,
  input logic [31:0] tx_ident_word,
  input logic [3:0]  tx_byte_count,
  input logic [63:0] tx_payload,
  input logic        tx_passthrough
);

  logic accept;
  logic fields_zero;
  logic deq_act;
  logic st_deq;
  logic plain_res;

  assign accept      = start && !busy;
  assign fields_zero = (tx_ident_word == '0) && (tx_byte_count == '0)
                    && (tx_payload == '0) && (tx_passthrough == 1'b0);
  assign deq_act     = (action == ACT_DEQ);
  assign st_deq      = (status == ST_DEQ) || (status == ST_EMPTY);
  assign plain_res   = done && (status != ST_DEQ);

  // Every accepted word yields a result, through the input register and then the result register.
  `CTXQ_ASSERT_NEXT(a_result_follows, clk, rst, accept, ##1 done, "result missing after word")

  // A result never appears without a word accepted ahead of it through the input and result registers.
  `CTXQ_ASSERT_NOW(a_no_spurious, clk, rst, done, $past(accept, 2), "result without a word")

  // Only a dequeue may report a dequeued message, and only a dequeue an empty ring.
  `CTXQ_ASSERT_NOW(a_status_action, clk, rst, done, st_deq == $past(deq_act, 2), "wrong status")

  // Results other than a dequeued message carry zero fields.
  `CTXQ_ASSERT_NOW(a_zero_fields, clk, rst, plain_res, fields_zero, "fields not zero")

endmodule

bind can_tx_queue_with_id_packing_core ctxq_checker u_ctxq_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .action         (action),
  .done           (done),
  .status         (status),
  .tx_ident_word  (tx_ident_word),
  .tx_byte_count  (tx_byte_count),
  .tx_payload     (tx_payload),
  .tx_passthrough (tx_passthrough)
);

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the CAN transmit queue: directed and random words against a predictor.
module tb;
  import ctxq_pkg::*;

  // The slowest correct run is about 1100 words, each behind a bounded random idle gap and
  // the pass through the input and result registers, plus a few drains. CYCLE_LIMIT stays
  // far above what such a run takes.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  // Results come after the input and result registers; SETTLE_CYCLES spare cycles catch any stray strobe.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_WORDS   = 135;

  // Kinds of entry in the list of pending stimulus: a command word, a write of the node id
  // register, or a pause until every outstanding result has come back.
  typedef enum logic [1:0] {
    WK_ITEM,
    WK_CFG,
    WK_DRAIN
  } word_kind_t;

  // Styles of random phase: a balanced mix, mostly enqueues (drives the ring full) and mostly
  // dequeues (drives it empty).
  typedef enum logic [1:0] {
    PH_MIXED,
    PH_FILL,
    PH_EMPTY
  } phase_style_t;

  typedef struct {
    word_kind_t  kind;
    item_t       item;
    logic [3:0]  node_id;
    int unsigned gap;
  } stim_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] ident;
    logic [3:0]  length;
    logic [63:0] payload;
    logic        mark;
  } tx_result_t;

  // Every input is known from time zero.
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        start        = 1'b0;
  logic [1:0]  action       = ACT_DEQ;
  logic [2:0]  msg_type     = '0;
  logic [3:0]  dest_node    = '0;
  logic [4:0]  table_number = '0;
  logic [10:0] var_offset   = '0;
  logic [28:0] raw_ident    = '0;
  logic [3:0]  byte_count   = '0;
  logic [63:0] payload      = '0;
  logic        passthrough  = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic [3:0]  cfg_data     = '0;
  logic        busy;
  logic        cfg_ready;
  logic        done;
  logic [1:0]  status;
  logic [31:0] tx_ident_word;
  logic [3:0]  tx_byte_count;
  logic [63:0] tx_payload;
  logic        tx_passthrough;

  can_tx_queue_with_id_packing_core u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .msg_type       (msg_type),
    .dest_node      (dest_node),
    .table_number   (table_number),
    .var_offset     (var_offset),
    .raw_ident      (raw_ident),
    .byte_count     (byte_count),
    .payload        (payload),
    .passthrough    (passthrough),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .done           (done),
    .status         (status),
    .tx_ident_word  (tx_ident_word),
    .tx_byte_count  (tx_byte_count),
    .tx_payload     (tx_payload),
    .tx_passthrough (tx_passthrough)
  );

  always #5 clk = ~clk;

  stim_word_t  pending_words[$];
  tx_result_t  expected_tx_results[$];
  item_t       driven_word;
  int unsigned words_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned failures       = 0;
  int unsigned cycle_count    = 0;

  // The testbench's own copy of the ring, its indices and the node id register.
  entry_t           ring_entries[DEPTH];
  logic [IDX_W-1:0] ring_wr_idx = '0;
  logic [IDX_W-1:0] ring_rd_idx = '0;
  logic [CNT_W-1:0] ring_fill   = '0;
  logic [3:0]       model_node_id = '0;

  // Applies one accepted word to the model of the ring and returns the result it gives.
  // Enqueues and empty dequeues report all message fields as zero.
  function automatic tx_result_t tx_queue_apply(input item_t w);
    tx_result_t res;
    entry_t     ent;
    res = '0;
    if (w.action == ACT_DEQ) begin
      if (ring_fill == 0) begin
        res.status = ST_EMPTY;
      end else begin
        ent         = ring_entries[ring_rd_idx];
        res.status  = ST_DEQ;
        res.ident   = ent.ident;
        res.length  = ent.length;
        res.payload = ent.payload;
        res.mark    = ent.mark;
        ring_rd_idx = (ring_rd_idx == IDX_W'(DEPTH - 1)) ? '0 : ring_rd_idx + 1'b1;
        ring_fill   = ring_fill - 1'b1;
      end
    end else if (ring_fill == CNT_W'(DEPTH)) begin
      // A full ring drops the word and moves nothing.
      res.status = ST_FULL;
    end else begin
      ent.length  = w.byte_count;
      ent.payload = w.payload;
      ent.mark    = 1'b0;
      case (w.action)
        ACT_PROTO: begin
          // Offset, message type, sender, destination, then the table number with its top
          // bit moved below the other four.
          ent.ident = {w.var_offset, 2'b00, w.msg_type, model_node_id, w.dest_node,
                       w.table_number[3:0], w.table_number[4], 3'b000} | SRR_IDE_BITS;
          ent.mark  = w.passthrough;
        end
        ACT_STD: begin
          ent.ident = {w.raw_ident[10:0], 21'd0};
        end
        default: begin
          // Extended identifier split around the SRR and IDE bits.
          ent.ident = {w.raw_ident[28:18], 2'b00, w.raw_ident[17:0], 1'b0} | SRR_IDE_BITS;
        end
      endcase
      ring_entries[ring_wr_idx] = ent;
      ring_wr_idx = (ring_wr_idx == IDX_W'(DEPTH - 1)) ? '0 : ring_wr_idx + 1'b1;
      ring_fill   = ring_fill + 1'b1;
      res.status  = ST_ENQ;
    end
    return res;
  endfunction

  function automatic item_t make_word(input logic [1:0] act, input logic [2:0] msg,
                                      input logic [3:0] dst, input logic [4:0] tab,
                                      input logic [10:0] off, input logic [28:0] raw,
                                      input logic [3:0] len, input logic [63:0] data,
                                      input logic pass);
    item_t w;
    w.action       = act;
    w.msg_type     = msg;
    w.dest_node    = dst;
    w.table_number = tab;
    w.var_offset   = off;
    w.raw_ident    = raw;
    w.byte_count   = len;
    w.payload      = data;
    w.passthrough  = pass;
    return w;
  endfunction

  // A word with random content. Lengths stay mostly within eight bytes, with the occasional
  // oversized one so that the top length bit is exercised.
  function automatic item_t random_word(input phase_style_t style);
    logic [1:0]  act;
    logic [3:0]  len;
    int unsigned roll;
    int unsigned deq_pct;
    roll = $urandom_range(0, 99);
    case (style)
      PH_FILL:  deq_pct = 15;
      PH_EMPTY: deq_pct = 75;
      default:  deq_pct = 45;
    endcase
    if (roll < deq_pct) begin
      act = ACT_DEQ;
    end else begin
      case ($urandom_range(0, 3))
        0, 1:    act = ACT_PROTO;
        2:       act = ACT_STD;
        default: act = ACT_EXT;
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      len = 4'($urandom_range(9, 15));
    end else begin
      len = 4'($urandom_range(0, 8));
    end
    return make_word(act, 3'($urandom), 4'($urandom), 5'($urandom), 11'($urandom),
                     29'($urandom), len, {$urandom, $urandom}, 1'($urandom));
  endfunction

  function automatic void push_word(input item_t w, input int unsigned gap);
    stim_word_t s;
    s.kind    = WK_ITEM;
    s.item    = w;
    s.node_id = '0;
    s.gap     = gap;
    pending_words.push_back(s);
  endfunction

  // The node id may only change while idle, so every write is preceded by a drain.
  function automatic void push_node_id_write(input logic [3:0] node);
    stim_word_t s;
    s.item    = '0;
    s.gap     = 0;
    s.node_id = '0;
    s.kind    = WK_DRAIN;
    pending_words.push_back(s);
    s.kind    = WK_CFG;
    s.node_id = node;
    pending_words.push_back(s);
  endfunction

  // Driver. It holds each word on the ports until start meets a low busy, then counts down
  // the gap that belongs to the next word before presenting it. A drain entry holds the
  // driver back until every accepted word has produced its result. start and cfg_valid each
  // get exactly one nonblocking assignment per edge, so start stays high across back-to-back words.
  always @(posedge clk) begin : driver
    logic        next_start;
    logic        next_cfg_valid;
    int unsigned accepted_now;
    next_start     = start;
    next_cfg_valid = cfg_valid;
    accepted_now   = words_accepted;
    if (rst) begin
      next_start     = 1'b0;
      next_cfg_valid = 1'b0;
    end else begin
      if (start && !busy) begin
        expected_tx_results.push_back(tx_queue_apply(driven_word));
        accepted_now = accepted_now + 1;
        next_start   = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        model_node_id  = cfg_data;
        next_cfg_valid = 1'b0;
      end
      if (!next_start && !next_cfg_valid && pending_words.size() > 0) begin
        case (pending_words[0].kind)
          WK_ITEM: begin
            if (pending_words[0].gap > 0) begin
              pending_words[0].gap = pending_words[0].gap - 1;
            end else begin
              driven_word  = pending_words[0].item;
              void'(pending_words.pop_front());
              action       <= driven_word.action;
              msg_type     <= driven_word.msg_type;
              dest_node    <= driven_word.dest_node;
              table_number <= driven_word.table_number;
              var_offset   <= driven_word.var_offset;
              raw_ident    <= driven_word.raw_ident;
              byte_count   <= driven_word.byte_count;
              payload      <= driven_word.payload;
              passthrough  <= driven_word.passthrough;
              next_start   = 1'b1;
            end
          end
          WK_CFG: begin
            cfg_data       <= pending_words[0].node_id;
            void'(pending_words.pop_front());
            next_cfg_valid = 1'b1;
          end
          default: begin
            // results_seen is updated by the monitor with a nonblocking assignment, so the
            // value read here is always that of the previous edge.
            if (accepted_now <= results_seen) begin
              void'(pending_words.pop_front());
            end
          end
        endcase
      end
    end
    start          <= next_start;
    cfg_valid      <= next_cfg_valid;
    words_accepted <= accepted_now;
  end

  // Monitor. Every done strobe is one result and is matched against the oldest expectation.
  always @(posedge clk) begin : monitor
    tx_result_t want;
    if (!rst && done) begin
      if (expected_tx_results.size() == 0) begin
        $error("result with no word outstanding: status %0d", status);
        failures = failures + 1;
      end else begin
        want = expected_tx_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          failures = failures + 1;
        end
        if (tx_ident_word !== want.ident) begin
          $error("tx_ident_word: expected %h, actual %h", want.ident, tx_ident_word);
          failures = failures + 1;
        end
        if (tx_byte_count !== want.length) begin
          $error("tx_byte_count: expected %0d, actual %0d", want.length, tx_byte_count);
          failures = failures + 1;
        end
        if (tx_payload !== want.payload) begin
          $error("tx_payload: expected %h, actual %h", want.payload, tx_payload);
          failures = failures + 1;
        end
        if (tx_passthrough !== want.mark) begin
          $error("tx_passthrough: expected %0d, actual %0d", want.mark, tx_passthrough);
          failures = failures + 1;
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog: a run that stalls anywhere ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [3:0]   phase_node;
    phase_style_t style;
    int unsigned  gap;

    // Directed part. The node id is set to its top value first, so the sender field is all
    // ones in the protocol words below.
    push_node_id_write(4'hf);
    // Dequeue from the empty ring, with every other field at its top value.
    push_word(make_word(ACT_DEQ, 3'h7, 4'hf, 5'h1f, 11'h7ff, 29'h1fffffff, 4'hf,
                        64'hffff_ffff_ffff_ffff, 1'b1), 0);
    // Protocol words: every field at its top value, then all zero, then the table number
    // with only its top bit set, then with only the low four bits set.
    push_word(make_word(ACT_PROTO, 3'h7, 4'hf, 5'h1f, 11'h7ff, 29'h0, 4'd8,
                        64'hffff_ffff_ffff_ffff, 1'b1), 0);
    push_word(make_word(ACT_PROTO, 3'h0, 4'h0, 5'h00, 11'h000, 29'h0, 4'd0,
                        64'h0, 1'b0), 0);
    push_word(make_word(ACT_PROTO, 3'h1, 4'hf, 5'h10, 11'h001, 29'h1fffffff, 4'd1,
                        64'h0123_4567_89ab_cdef, 1'b1), 0);
    push_word(make_word(ACT_PROTO, 3'h4, 4'h0, 5'h0f, 11'h400, 29'h0, 4'd15,
                        64'h8000_0000_0000_0001, 1'b0), 0);
    // Raw standard identifiers: only the low eleven bits count and the mark is cleared.
    // The all-zero one gives an identifier word of zero and a length above eight.
    push_word(make_word(ACT_STD, 3'h7, 4'hf, 5'h1f, 11'h7ff, 29'h1fffffff, 4'd8,
                        64'hdead_beef_cafe_f00d, 1'b1), 0);
    push_word(make_word(ACT_STD, 3'h0, 4'h0, 5'h00, 11'h000, 29'h0, 4'd9,
                        64'h0, 1'b0), 0);
    push_word(make_word(ACT_STD, 3'h0, 4'h0, 5'h00, 11'h000, 29'h400, 4'd2,
                        64'h5555_5555_5555_5555, 1'b1), 0);
    // Raw extended identifiers: all ones, all zero, and each side of the SRR/IDE split.
    push_word(make_word(ACT_EXT, 3'h7, 4'hf, 5'h1f, 11'h7ff, 29'h1fffffff, 4'd12,
                        64'haaaa_aaaa_aaaa_aaaa, 1'b1), 0);
    push_word(make_word(ACT_EXT, 3'h0, 4'h0, 5'h00, 11'h000, 29'h0, 4'd0,
                        64'h0, 1'b0), 0);
    push_word(make_word(ACT_EXT, 3'h0, 4'h0, 5'h00, 11'h000, 29'h0003ffff, 4'd4,
                        64'h00ff_00ff_00ff_00ff, 1'b0), 0);
    push_word(make_word(ACT_EXT, 3'h0, 4'h0, 5'h00, 11'h000, 29'h1ffc0000, 4'd7,
                        64'hff00_ff00_ff00_ff00, 1'b1), 0);
    // Five more enqueues fill the ring; the two after them must be dropped as full.
    repeat (5) begin
      push_word(random_word(PH_FILL), 0);
      pending_words[pending_words.size() - 1].item.action = ACT_PROTO;
    end
    push_word(make_word(ACT_PROTO, 3'h2, 4'h3, 5'h04, 11'h055, 29'h0, 4'd3,
                        64'h1111_2222_3333_4444, 1'b1), 0);
    push_word(make_word(ACT_EXT, 3'h0, 4'h0, 5'h00, 11'h000, 29'h12345678, 4'd5,
                        64'h4444_3333_2222_1111, 1'b0), 0);
    // Dequeue the first six entries, the zero identifier among them.
    repeat (6) push_word(make_word(ACT_DEQ, 3'h0, 4'h0, 5'h00, 11'h000, 29'h0, 4'd0,
                                   64'h0, 1'b0), 0);

    // Random part. Each phase starts idle with a new node id, the extremes included, and
    // has its own balance of enqueues to dequeues so that the ring swings between full and
    // empty. Idle bursts come in some phases only, and never in the last one.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0, 6:    phase_node = 4'h0;
        2, 7:    phase_node = 4'hf;
        4:       phase_node = 4'h7;
        default: phase_node = 4'($urandom);
      endcase
      push_node_id_write(phase_node);
      case (p % 3)
        1:       style = PH_FILL;
        2:       style = PH_EMPTY;
        default: style = PH_MIXED;
      endcase
      for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
        gap = 0;
        if (p != 2 && p != RANDOM_PHASES - 1 && $urandom_range(0, 3) == 0) begin
          gap = $urandom_range(1, 13);
        end
        push_word(random_word(style), gap);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait until every word has gone in and every result has come back, then give any
    // stray strobe a few cycles to show itself.
    do begin
      @(negedge clk);
    end while (pending_words.size() != 0 || start || cfg_valid ||
               words_accepted != results_seen);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_tx_results.size() != 0) begin
      $error("%0d results never arrived", expected_tx_results.size());
      failures = failures + 1;
    end
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
